// ===== hw/rtl/periodic_task_scheduler_assert.svh =====
// assertion macros for the periodic task scheduler
`ifndef PERIODIC_TASK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define PTS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pts assertion failed");

// condition must hold in the cycle after the trigger
`define PTS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pts assertion failed");

`endif

// ===== hw/rtl/pts_pkg.sv =====
// shared types and constants for the periodic task scheduler
package pts_pkg;

    localparam int NUM_TASKS_DEF = 16;
    localparam int TIME_W        = 32;
    localparam int TICK_W        = 10;
    localparam int PEND_W        = 8;
    localparam int SLOT_W        = 4;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int WORD_W        = 2 * TIME_W + PEND_W;

    localparam logic [TICK_W-1:0] TICK_RST = TICK_W'(10);
    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD      = 2'd0,
        FUNC_TICK     = 2'd1,
        FUNC_DISPATCH = 2'd2,
        FUNC_DELETE   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_TICKED  = 3'd2,
        ST_DELETED = 3'd3,
        ST_RUN     = 3'd4,
        ST_NONE    = 3'd5
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic    latch;
        logic    div_start;
        logic    idx_clr;
        logic    idx_inc;
        logic    ram_rd;
        logic    tick_wr;
        logic    dsp_wr;
        logic    add_wr;
        logic    del;
        logic    held_clr;
        logic    emit;
        t_status status;
        logic    last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic idx_used;
        logic idx_last;
        logic hit;
        logic held_valid;
        logic out_free;
        logic div_done;
    } t_sts;

endpackage

// ===== hw/rtl/pts_if.sv =====
// valid/ready channel interfaces for the scheduler input and result beats
interface pts_in_if;
    import pts_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] delay_ms;
    logic [TIME_W-1:0] period_ms;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output func, output delay_ms, output period_ms,
                    output slot, input ready);
    modport sink   (input valid, input func, input delay_ms, input period_ms,
                    input slot, output ready);
endinterface

interface pts_out_if;
    import pts_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   task_slot;
    logic                one_shot_freed;
    logic                last;

    modport source (output valid, output status, output task_slot,
                    output one_shot_freed, output last, input ready);
    modport sink   (input valid, input status, input task_slot,
                    input one_shot_freed, input last, output ready);
endinterface

// ===== hw/rtl/pts_ram.sv =====
// generic single-port-pair ram with registered read
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/pts_div.sv =====
// two-lane restoring divider, one quotient bit per lane per cycle
module pts_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pts_pkg::TIME_W-1:0] i_dvd_a,
    input  logic [pts_pkg::TIME_W-1:0] i_dvd_b,
    input  logic [pts_pkg::TICK_W-1:0] i_dvs,
    output logic                      o_done,
    output logic [pts_pkg::TIME_W-1:0] o_quo_a,
    output logic [pts_pkg::TIME_W-1:0] o_quo_b
);
    import pts_pkg::*;

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [TICK_W-1:0] r_dvs;
    logic [TIME_W-1:0] r_q   [2];
    logic [TICK_W-1:0] r_rem [2];
    logic [TIME_W-1:0] n_q   [2];
    logic [TICK_W-1:0] n_rem [2];
    logic [TICK_W:0]   w_try [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_try[k] = {r_rem[k], r_q[k][TIME_W-1]};
            if (w_try[k] >= {1'b0, r_dvs}) begin
                n_rem[k] = TICK_W'(w_try[k] - {1'b0, r_dvs});
                n_q[k]   = {r_q[k][TIME_W-2:0], 1'b1};
            end else begin
                n_rem[k] = w_try[k][TICK_W-1:0];
                n_q[k]   = {r_q[k][TIME_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(TIME_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs    <= i_dvs;
            r_q[0]   <= i_dvd_a;
            r_q[1]   <= i_dvd_b;
            r_rem[0] <= '0;
            r_rem[1] <= '0;
        end else if (r_cnt != '0) begin
            r_q[0]   <= n_q[0];
            r_q[1]   <= n_q[1];
            r_rem[0] <= n_rem[0];
            r_rem[1] <= n_rem[1];
        end
    end

    assign o_done  = (r_cnt == '0);
    assign o_quo_a = r_q[0];
    assign o_quo_b = r_q[1];
endmodule

// ===== hw/rtl/pts_dp.sv =====
// scheduler datapath: task table, divider, slot walker and result register
module pts_dp #(
    parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pts_pkg::TICK_W-1:0]   i_cfg_wdata,
    input  pts_pkg::t_cmd               i_cmd,
    output pts_pkg::t_sts               o_sts,
    input  logic [pts_pkg::TIME_W-1:0]   i_delay_ms,
    input  logic [pts_pkg::TIME_W-1:0]   i_period_ms,
    input  logic [pts_pkg::SLOT_W-1:0]   i_slot,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [pts_pkg::STATUS_W-1:0] o_status,
    output logic [pts_pkg::SLOT_W-1:0]   o_task_slot,
    output logic                        o_one_shot_freed,
    output logic                        o_last
);
    import pts_pkg::*;

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    logic [TICK_W-1:0]    r_tick_ms;
    logic [NUM_TASKS-1:0] r_used;
    logic [IDX_W-1:0]     r_idx;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_held_valid;
    logic [IDX_W-1:0]     r_held_idx;
    logic                 r_held_freed;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_freed;
    logic                 r_out_last;

    logic [TICK_W-1:0] w_dvs;
    logic              w_div_done;
    logic [TIME_W-1:0] w_q_delay;
    logic [TIME_W-1:0] w_q_period;
    logic [WORD_W-1:0] w_rdata;
    logic [WORD_W-1:0] w_wdata;
    logic              w_we;
    logic [TIME_W-1:0] w_cd;
    logic [TIME_W-1:0] w_per;
    logic [PEND_W-1:0] w_pend;
    logic [TIME_W-1:0] w_tick_cd;
    logic [PEND_W-1:0] w_tick_pend;
    logic              w_del_ok;
    logic              w_out_free;

    // a zero tick length divides as one
    assign w_dvs = (r_tick_ms == '0) ? TICK_W'(1) : r_tick_ms;

    pts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd_a (i_delay_ms),
        .i_dvd_b (i_period_ms),
        .i_dvs   (w_dvs),
        .o_done  (w_div_done),
        .o_quo_a (w_q_delay),
        .o_quo_b (w_q_period)
    );

    pts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign {w_cd, w_per, w_pend} = w_rdata;

    always_comb begin
        w_tick_cd   = w_cd;
        w_tick_pend = w_pend;
        if (w_cd == '0) begin
            if (w_pend != PEND_MAX) begin
                w_tick_pend = w_pend + 1'b1;
            end
            if (w_per != '0) begin
                w_tick_cd = w_per;
            end
        end else begin
            w_tick_cd = w_cd - 1'b1;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = w_rdata;
        priority if (i_cmd.add_wr) begin
            w_we    = 1'b1;
            w_wdata = {w_q_delay, w_q_period, PEND_W'(0)};
        end else if (i_cmd.tick_wr) begin
            w_we    = r_used[r_idx];
            w_wdata = {w_tick_cd, w_per, w_tick_pend};
        end else if (i_cmd.dsp_wr) begin
            w_we    = 1'b1;
            w_wdata = {w_cd, w_per, w_pend - 1'b1};
        end else begin
            w_we    = 1'b0;
        end
    end

    assign w_del_ok   = (int'(r_slot) < NUM_TASKS);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms <= TICK_RST;
        end else if (i_cfg_we) begin
            r_tick_ms <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            if (i_cmd.add_wr) begin
                r_used[r_idx] <= 1'b1;
            end
            if (i_cmd.dsp_wr && (w_per == '0)) begin
                r_used[r_idx] <= 1'b0;
            end
            if (i_cmd.del && w_del_ok) begin
                r_used[IDX_W'(r_slot)] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_slot <= i_slot;
        end
    end

    // one dispatched slot is held back until it is known whether another follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
        end else if (i_cmd.dsp_wr) begin
            r_held_valid <= 1'b1;
        end else if (i_cmd.held_clr) begin
            r_held_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dsp_wr) begin
            r_held_idx   <= r_idx;
            r_held_freed <= (w_per == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.status;
            r_out_last   <= i_cmd.last;
            r_out_freed  <= 1'b0;
            unique case (i_cmd.status)
                ST_ADDED: begin
                    r_out_slot <= SLOT_W'(r_idx);
                end
                ST_DELETED: begin
                    r_out_slot <= r_slot;
                end
                ST_RUN: begin
                    r_out_slot  <= SLOT_W'(r_held_idx);
                    r_out_freed <= r_held_freed;
                end
                default: begin
                    r_out_slot <= '0;
                end
            endcase
        end
    end

    assign o_sts.idx_used   = r_used[r_idx];
    assign o_sts.idx_last   = (r_idx == IDX_W'(NUM_TASKS - 1));
    assign o_sts.hit        = r_used[r_idx] && (w_pend != '0);
    assign o_sts.held_valid = r_held_valid;
    assign o_sts.out_free   = w_out_free;
    assign o_sts.div_done   = w_div_done;

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_task_slot      = r_out_slot;
    assign o_one_shot_freed = r_out_freed;
    assign o_last           = r_out_last;
endmodule

// ===== hw/rtl/pts_ctrl.sv =====
// scheduler controller: sequences add, tick, dispatch and delete
`include "periodic_task_scheduler_assert.svh"

module pts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  pts_pkg::t_func i_func,
    output logic           o_in_ready,
    input  pts_pkg::t_sts  i_sts,
    output pts_pkg::t_cmd  o_cmd
);
    import pts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_FULL,
        S_ADD_DIV,
        S_TICK_RD,
        S_TICK_WB,
        S_TICK_END,
        S_DSP_RD,
        S_DSP_WB,
        S_DSP_END,
        S_DEL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    unique case (i_func)
                        FUNC_ADD: begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_ADD_SCAN;
                        end
                        FUNC_TICK:     n_state = S_TICK_RD;
                        FUNC_DISPATCH: n_state = S_DSP_RD;
                        FUNC_DELETE:   n_state = S_DEL;
                    endcase
                end
            end
            S_ADD_SCAN: begin
                priority if (!i_sts.idx_used) begin
                    n_state = S_ADD_DIV;
                end else if (i_sts.idx_last) begin
                    n_state = S_ADD_FULL;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_ADD_FULL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_FULL;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ADD_DIV: begin
                if (i_sts.div_done && i_sts.out_free) begin
                    o_cmd.add_wr = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_ADDED;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_TICK_RD: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_TICK_WB;
            end
            S_TICK_WB: begin
                o_cmd.tick_wr = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_TICK_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_TICK_RD;
                end
            end
            S_TICK_END: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_TICKED;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DSP_RD: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_DSP_WB;
            end
            S_DSP_WB: begin
                // a ready slot pushes out the previously held one, which is not last
                if (!(i_sts.hit && i_sts.held_valid && !i_sts.out_free)) begin
                    if (i_sts.hit) begin
                        o_cmd.dsp_wr = 1'b1;
                        if (i_sts.held_valid) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_RUN;
                        end
                    end
                    if (i_sts.idx_last) begin
                        n_state = S_DSP_END;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_DSP_RD;
                    end
                end
            end
            S_DSP_END: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.status   = i_sts.held_valid ? ST_RUN : ST_NONE;
                    o_cmd.last     = 1'b1;
                    o_cmd.held_clr = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DEL: begin
                if (i_sts.out_free) begin
                    o_cmd.del    = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_DELETED;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `PTS_ASSERT_NOW(a_emit_free, o_cmd.emit, i_sts.out_free)
    `PTS_ASSERT_NEXT(a_accept_busy, i_in_valid && o_in_ready, !o_in_ready)
    `PTS_ASSERT_NOW(a_add_ready, o_cmd.add_wr, i_sts.div_done && !i_sts.idx_used)
    `PTS_ASSERT_NOW(a_dsp_hit, o_cmd.dsp_wr, i_sts.hit)
endmodule

// ===== hw/rtl/periodic_task_scheduler.sv =====
// top level of the periodic task scheduler
// usage:
// - i_in carries one command beat (func, delay_ms, period_ms, slot); o_out carries
//   result beats (status, task_slot, one_shot_freed, last); last marks a command's end
// - i_cfg_we/i_cfg_wdata write tick_ms; write only while no command is in flight
// - one command at a time: ready drops after each accepted beat until the command's
//   final result sits in the output register
// - add: free-slot walk (one slot per cycle) runs beside a 32-step divider, and the
//   added result waits for the divider as well as the walk
// - tick: each slot takes a table read and a write-back
// - dispatch: same walk as tick, which also waits through any output stalls
// - reset clears the slot-used bits and sets tick_ms to 10; the task table ram is
//   not cleared, a slot's entry is only acted on once its used bit is set
// - a stalled receiver holds the output register; the walk waits in place whenever
//   a new result has nowhere to go, and nothing is dropped
module periodic_task_scheduler #(
    parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pts_pkg::TICK_W-1:0] i_cfg_wdata,
    pts_in_if.sink                    i_in,
    pts_out_if.source                 o_out
);
    import pts_pkg::*;

    t_cmd  w_cmd;
    t_sts  w_sts;
    t_func w_func;

    // command field is a raw two-bit code on the channel
    assign w_func = t_func'(i_in.func);

    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_func     (w_func),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pts_dp #(
        .NUM_TASKS (NUM_TASKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_delay_ms       (i_in.delay_ms),
        .i_period_ms      (i_in.period_ms),
        .i_slot           (i_in.slot),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_status         (o_out.status),
        .o_task_slot      (o_out.task_slot),
        .o_one_shot_freed (o_out.one_shot_freed),
        .o_last           (o_out.last)
    );
endmodule
